// ----- rtl/sorted_priority_queue_assert.svh -----
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check failed");

`endif

// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_err;

    localparam t_req REQ_INSERT = 2'd0;
    localparam t_req REQ_REMOVE = 2'd1;
    localparam t_req REQ_CLEAR  = 2'd2;

    localparam t_err ERR_OK    = 2'd0;
    localparam t_err ERR_FULL  = 2'd1;
    localparam t_err ERR_EMPTY = 2'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
        logic clr;
    } t_spq_ctrl;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int TAG_WIDTH      = 16,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  spq_pkg::t_spq_ctrl              i_ctrl,
    input  wire        [TAG_WIDTH-1:0]      i_new_tag,
    input  wire signed [PRIORITY_WIDTH-1:0] i_new_prio,
    input  wire        [TAG_WIDTH-1:0]      i_left_tag,
    input  wire signed [PRIORITY_WIDTH-1:0] i_left_prio,
    input  wire                             i_left_valid,
    input  wire                             i_left_keep,
    input  wire        [TAG_WIDTH-1:0]      i_right_tag,
    input  wire signed [PRIORITY_WIDTH-1:0] i_right_prio,
    input  wire                             i_right_valid,
    output logic       [TAG_WIDTH-1:0]      o_tag,
    output logic signed [PRIORITY_WIDTH-1:0] o_prio,
    output logic                            o_valid,
    output logic                            o_keep
);
    import spq_pkg::*;

    logic        [TAG_WIDTH-1:0]      r_tag,   n_tag;
    logic signed [PRIORITY_WIDTH-1:0] r_prio,  n_prio;
    logic                             r_valid, n_valid;

    // hold this entry on insert when it ranks at or ahead of the new one
    assign o_keep  = r_valid && (r_prio <= i_new_prio);
    assign o_tag   = r_tag;
    assign o_prio  = r_prio;
    assign o_valid = r_valid;

    always_comb begin
        n_tag   = r_tag;
        n_prio  = r_prio;
        n_valid = r_valid;
        if (i_ctrl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctrl.ins) begin
            n_valid = i_left_valid;
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_tag  = i_new_tag;
                    n_prio = i_new_prio;
                end else begin
                    n_tag  = i_left_tag;
                    n_prio = i_left_prio;
                end
            end
        end else if (i_ctrl.rem) begin
            n_valid = i_right_valid;
            n_tag   = i_right_tag;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// The result strobe o_result_valid rises in the cycle after the transfer of a request.
// Throughput: one request per cycle outside reset; every cell of the chain updates in parallel each cycle.
// busy is high only while i_rst_n is low; results cannot be stalled by the receiver.
// Reset (synchronous, active low) empties the queue and drops any result in flight.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int TAG_WIDTH      = 16,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       start,
    output logic                                      busy,
    input  spq_pkg::t_req                             i_req_type,
    input  wire        [TAG_WIDTH-1:0]                i_item_tag,
    input  wire signed [PRIORITY_WIDTH-1:0]           i_item_priority,
    output logic                                      o_result_valid,
    output logic       [TAG_WIDTH-1:0]                o_removed_tag,
    output logic                                      o_removed_valid,
    output logic       [TAG_WIDTH-1:0]                o_head_tag,
    output logic signed [PRIORITY_WIDTH-1:0]          o_head_priority,
    output logic                                      o_head_valid,
    output logic       [$clog2(QUEUE_DEPTH+1)-1:0]    o_entry_count,
    output spq_pkg::t_err                             o_error_code
);
    import spq_pkg::*;

    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

    // Chain state: cell 0 is the head, entries are valid as a thermometer
    // from cell 0 upward, and priorities ascend along the valid cells.
    logic        [TAG_WIDTH-1:0]      w_tag   [QUEUE_DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] w_prio  [QUEUE_DEPTH];
    logic                             w_valid [QUEUE_DEPTH];
    logic                             w_keep  [QUEUE_DEPTH];

    logic        [TAG_WIDTH-1:0]      w_left_tag    [QUEUE_DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] w_left_prio   [QUEUE_DEPTH];
    logic                             w_left_valid  [QUEUE_DEPTH];
    logic                             w_left_keep   [QUEUE_DEPTH];
    logic        [TAG_WIDTH-1:0]      w_right_tag   [QUEUE_DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] w_right_prio  [QUEUE_DEPTH];
    logic                             w_right_valid [QUEUE_DEPTH];

    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    t_spq_ctrl             w_ctrl;

    logic                  r_result_valid;
    logic                  r_removed_valid;
    logic [TAG_WIDTH-1:0]  r_removed_tag;
    t_err                  r_error_code,  n_error_code;
    logic [CountWidth-1:0] r_count,       n_count;

    // Requests are refused only while reset holds the chain.
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;
    assign w_full   = w_valid[QUEUE_DEPTH-1];
    assign w_empty  = !w_valid[0];

    // Turn a transfer into a chain command; a refused insert or remove
    // leaves every cell untouched, and request code 3 does nothing.
    always_comb begin
        w_ctrl.ins = w_accept && (i_req_type == REQ_INSERT) && !w_full;
        w_ctrl.rem = w_accept && (i_req_type == REQ_REMOVE) && !w_empty;
        w_ctrl.clr = w_accept && (i_req_type == REQ_CLEAR);
    end

    always_comb begin
        n_error_code = ERR_OK;
        if (i_req_type == REQ_INSERT && w_full) begin
            n_error_code = ERR_FULL;
        end else if (i_req_type == REQ_REMOVE && w_empty) begin
            n_error_code = ERR_EMPTY;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.clr) begin
            n_count = '0;
        end else if (w_ctrl.ins) begin
            n_count = r_count + CountWidth'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CountWidth'(1);
        end
    end

    // Wire each cell to its neighbors. The slot left of the head always
    // holds, so the new entry lands at the head when nothing ranks ahead;
    // the slot right of the tail reads as empty, so a remove drains it.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left_tag[g]   = i_item_tag;
                assign w_left_prio[g]  = i_item_priority;
                assign w_left_valid[g] = 1'b1;
                assign w_left_keep[g]  = 1'b1;
            end else begin : g_inner_left
                assign w_left_tag[g]   = w_tag[g-1];
                assign w_left_prio[g]  = w_prio[g-1];
                assign w_left_valid[g] = w_valid[g-1];
                assign w_left_keep[g]  = w_keep[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right_tag[g]   = i_item_tag;
                assign w_right_prio[g]  = i_item_priority;
                assign w_right_valid[g] = 1'b0;
            end else begin : g_inner_right
                assign w_right_tag[g]   = w_tag[g+1];
                assign w_right_prio[g]  = w_prio[g+1];
                assign w_right_valid[g] = w_valid[g+1];
            end

            spq_cell #(
                .TAG_WIDTH      (TAG_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_tag     (i_item_tag),
                .i_new_prio    (i_item_priority),
                .i_left_tag    (w_left_tag[g]),
                .i_left_prio   (w_left_prio[g]),
                .i_left_valid  (w_left_valid[g]),
                .i_left_keep   (w_left_keep[g]),
                .i_right_tag   (w_right_tag[g]),
                .i_right_prio  (w_right_prio[g]),
                .i_right_valid (w_right_valid[g]),
                .o_tag         (w_tag[g]),
                .o_prio        (w_prio[g]),
                .o_valid       (w_valid[g]),
                .o_keep        (w_keep[g])
            );
        end
    endgenerate

    // Control state: result strobe, removed flag and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid  <= 1'b0;
            r_removed_valid <= 1'b0;
            r_count         <= '0;
        end else begin
            r_result_valid  <= w_accept;
            r_removed_valid <= w_ctrl.rem;
            r_count         <= n_count;
        end
    end

    // Result payload: on each transfer, capture the error code and the outgoing head on a remove (zero otherwise).
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed_tag <= w_ctrl.rem ? w_tag[0] : '0;
            r_error_code  <= n_error_code;
        end
    end

    // The head cell already holds the post-step head when the strobe is up.
    assign o_result_valid  = r_result_valid;
    assign o_removed_tag   = r_removed_tag;
    assign o_removed_valid = r_removed_valid;
    assign o_head_valid    = w_valid[0];
    assign o_head_tag      = w_valid[0] ? w_tag[0]  : '0;
    assign o_head_priority = w_valid[0] ? w_prio[0] : '0;
    assign o_entry_count   = r_count;
    assign o_error_code    = r_error_code;

endmodule

`default_nettype wire

// ----- rtl/spq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int TAG_WIDTH      = 16,
    parameter int PRIORITY_WIDTH = 16
) (
    input wire                                    i_clk,
    input wire                                    i_rst_n,
    input wire                                    start,
    input wire                                    busy,
    input wire                                    o_result_valid,
    input wire [TAG_WIDTH-1:0]                    o_removed_tag,
    input wire                                    o_removed_valid,
    input wire [PRIORITY_WIDTH-1:0]               o_head_priority,
    input wire                                    o_head_valid,
    input wire [$clog2(QUEUE_DEPTH+1)-1:0]        o_entry_count,
    input spq_pkg::t_err                          o_error_code
);
    import spq_pkg::*;

    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

    `SPQ_ASSERT_NEXT(a_one_result_per_transfer, i_clk, i_rst_n,
        start && !busy, o_result_valid)
    `SPQ_ASSERT_NEXT(a_no_result_without_transfer, i_clk, i_rst_n,
        !(start && !busy), !o_result_valid)
    `SPQ_ASSERT_NOW(a_head_matches_count, i_clk, i_rst_n,
        o_result_valid, o_head_valid == (o_entry_count != '0))
    `SPQ_ASSERT_NOW(a_full_error_only_when_full, i_clk, i_rst_n,
        o_result_valid && (o_error_code == ERR_FULL),
        o_entry_count == CountWidth'(QUEUE_DEPTH) && !o_removed_valid)
    `SPQ_ASSERT_NOW(a_empty_error_reports_empty, i_clk, i_rst_n,
        o_result_valid && (o_error_code == ERR_EMPTY),
        o_entry_count == '0 && !o_head_valid && o_head_priority == '0 &&
        o_removed_tag == '0)

endmodule

bind sorted_priority_queue spq_checker #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .TAG_WIDTH      (TAG_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_removed_tag   (o_removed_tag),
    .o_removed_valid (o_removed_valid),
    .o_head_priority (o_head_priority),
    .o_head_valid    (o_head_valid),
    .o_entry_count   (o_entry_count),
    .o_error_code    (o_error_code)
);

`default_nettype wire
